FILE: rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared sizes, character codes, status codes and transaction types for the
// reverse Polish expression evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  // Stack and word sizes.
  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W      = $clog2(VALUE_WIDTH + 1);

  // ASCII codes that the decoder recognizes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic [VALUE_WIDTH-1:0] word_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADCHAR  = 3'd1,
    ST_FEW      = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_NOTONE   = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // Input transaction: one character of the expression.
  typedef struct packed {
    logic [7:0] symbol;
    logic       is_last;
  } item_t;

  // Output transaction: final value and status.
  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
  } result_t;

endpackage

FILE: rtl/rpn_stack.sv
// ----------------------------------------------------------------------------
// RPN operand stack
// Operand storage with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rpn_stack (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [rpn_pkg::ADDR_W-1:0]  wr_addr,
  input  rpn_pkg::word_t              wr_data,
  input  logic [rpn_pkg::ADDR_W-1:0]  rd_addr_a,
  input  logic [rpn_pkg::ADDR_W-1:0]  rd_addr_b,
  output rpn_pkg::word_t              rd_data_a,
  output rpn_pkg::word_t              rd_data_b
);
  import rpn_pkg::*;

  word_t mem [STACK_DEPTH];

  // Write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: rtl/rpn_alu.sv
// ----------------------------------------------------------------------------
// RPN arithmetic unit
// One shared adder/subtractor runs add, subtract, and iteratively a shift-add multiply and
// a restoring signed division.
// ----------------------------------------------------------------------------
module rpn_alu (
  input  logic               clk,
  input  logic               rst,
  input  rpn_pkg::alu_req_t  req,
  input  rpn_pkg::word_t     lhs,
  input  rpn_pkg::word_t     rhs,
  output logic               done,
  output rpn_pkg::word_t     res
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ONE,
    A_MUL,
    A_DIV,
    A_FIX
  } astate_t;

  astate_t             state;
  alu_op_t             op;
  word_t               acc;
  word_t               opb;
  word_t               quo;
  logic                neg;
  logic [STEP_W-1:0]   steps;
  word_t               add_a;
  word_t               add_b;
  logic                add_sub;
  logic [VALUE_WIDTH:0] sum;
  word_t               shifted;
  word_t               lhs_mag;
  word_t               rhs_mag;

  // Partial remainder shifted left with the next dividend bit.
  assign shifted = {acc[VALUE_WIDTH-2:0], quo[VALUE_WIDTH-1]};

  // Operand magnitudes for division.
  assign lhs_mag = lhs[VALUE_WIDTH-1] ? (~lhs + word_t'(1)) : lhs;
  assign rhs_mag = rhs[VALUE_WIDTH-1] ? (~rhs + word_t'(1)) : rhs;

  // Operand selection for the shared adder.
  always_comb begin
    add_a   = acc;
    add_b   = opb;
    add_sub = 1'b0;
    unique case (state)
      A_ONE: add_sub = (op == ALU_SUB);
      A_MUL: add_b = quo[0] ? opb : '0;
      A_DIV: begin
        add_a   = shifted;
        add_sub = 1'b1;
      end
      A_FIX: begin
        add_a   = '0;
        add_b   = quo;
        add_sub = neg;
      end
      default: ;
    endcase
  end

  // The shared adder; the top bit is the carry, set on subtract when a >= b.
  assign sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
             + {{VALUE_WIDTH{1'b0}}, add_sub};

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        A_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            op <= req.op;
            unique case (req.op) inside
              ALU_ADD, ALU_SUB: begin
                acc   <= lhs;
                opb   <= rhs;
                state <= A_ONE;
              end
              ALU_MUL: begin
                acc   <= '0;
                opb   <= lhs;
                quo   <= rhs;
                steps <= STEP_W'(VALUE_WIDTH);
                state <= A_MUL;
              end
              default: begin
                acc   <= '0;
                opb   <= rhs_mag;
                quo   <= lhs_mag;
                neg   <= lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1];
                steps <= STEP_W'(VALUE_WIDTH);
                state <= A_DIV;
              end
            endcase
          end
        end
        A_ONE: begin
          res   <= sum[VALUE_WIDTH-1:0];
          done  <= 1'b1;
          state <= A_IDLE;
        end
        A_MUL: begin
          acc   <= sum[VALUE_WIDTH-1:0];
          opb   <= {opb[VALUE_WIDTH-2:0], 1'b0};
          quo   <= {1'b0, quo[VALUE_WIDTH-1:1]};
          steps <= steps - STEP_W'(1);
          done  <= (steps == STEP_W'(1));
          if (steps == STEP_W'(1)) begin
            res   <= sum[VALUE_WIDTH-1:0];
            state <= A_IDLE;
          end
        end
        A_DIV: begin
          done <= 1'b0;
          if (sum[VALUE_WIDTH]) begin
            acc <= sum[VALUE_WIDTH-1:0];
            quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
          end else begin
            acc <= shifted;
            quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
          end
          steps <= steps - STEP_W'(1);
          if (steps == STEP_W'(1)) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          res   <= sum[VALUE_WIDTH-1:0];
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/rpn_expression_evaluator.sv
// Each character is registered in S_IDLE and decoded in S_DECODE; a valid
// operator then waits in S_EXEC for the iterative shared adder in rpn_alu,
// which runs multiply and divide over the operand bits. A last character
// passes S_SYNC and S_RESULT before the result transaction is offered.
// One character at a time; item_stall is high until the current one is done.
// Reset (synchronous, active high) empties the stack and clears the error.
// ----------------------------------------------------------------------------
// RPN expression evaluator
// Stack calculator that takes one character per transaction and returns the
// value and status of the expression after its last character.
// ----------------------------------------------------------------------------
module rpn_expression_evaluator (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  rpn_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output rpn_pkg::result_t  result
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_SYNC,
    S_RESULT
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   count;
  status_t              err;
  logic [7:0]           sym_q;
  logic                 last_q;

  logic [COUNT_W-1:0]   cnt_m1;
  logic [COUNT_W-1:0]   cnt_m2;
  logic                 is_digit;
  logic                 is_oper;
  logic                 is_blank;
  logic                 full;
  logic                 div_zero;
  alu_op_t              oper;
  alu_req_t             alu_req;
  logic                 alu_done;
  word_t                alu_res;
  logic                 digit_push;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  word_t                wr_data;
  word_t                rd_rhs;
  word_t                rd_lhs;
  result_t              result_next;

  assign item_stall = (state != S_IDLE);

  // Stack-count helpers and character classification.
  assign cnt_m1   = count - COUNT_W'(1);
  assign cnt_m2   = count - COUNT_W'(2);
  assign is_digit = (sym_q >= CH_ZERO) && (sym_q <= CH_NINE);
  assign is_oper  = (sym_q == CH_PLUS) || (sym_q == CH_MINUS) ||
                    (sym_q == CH_STAR) || (sym_q == CH_SLASH);
  assign is_blank = (sym_q == CH_SPACE) || ((sym_q >= CH_TAB) && (sym_q <= CH_CR));
  assign full     = (count >= COUNT_W'(STACK_DEPTH));
  assign div_zero = (sym_q == CH_SLASH) && (rd_rhs == '0);

  // Operator decode.
  always_comb begin
    case (sym_q)
      CH_MINUS: oper = ALU_SUB;
      CH_STAR:  oper = ALU_MUL;
      CH_SLASH: oper = ALU_DIV;
      default:  oper = ALU_ADD;
    endcase
  end

  // Launch of the arithmetic unit for a valid operator.
  assign alu_req.start = (state == S_DECODE) && (err == ST_OK) && is_oper &&
                         (count >= COUNT_W'(2)) && !div_zero;
  assign alu_req.op    = oper;

  // Stack write: a digit push, or the operator result over the left operand.
  assign digit_push = (state == S_DECODE) && (err == ST_OK) && is_digit && !full;
  assign wr_en      = digit_push || ((state == S_EXEC) && alu_done);
  assign wr_addr    = (state == S_EXEC) ? cnt_m2[ADDR_W-1:0] : count[ADDR_W-1:0];
  assign wr_data    = (state == S_EXEC) ? alu_res : word_t'(sym_q - CH_ZERO);

  rpn_stack u_stack (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (cnt_m1[ADDR_W-1:0]),
    .rd_addr_b (cnt_m2[ADDR_W-1:0]),
    .rd_data_a (rd_rhs),
    .rd_data_b (rd_lhs)
  );

  rpn_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .lhs  (rd_lhs),
    .rhs  (rd_rhs),
    .done (alu_done),
    .res  (alu_res)
  );

  // Final status and value of the expression.
  always_comb begin
    result_next.value  = '0;
    result_next.status = err;
    if (err == ST_OK) begin
      if (count != COUNT_W'(1)) begin
        result_next.status = ST_NOTONE;
      end else begin
        result_next.value = 32'(rd_rhs);
      end
    end
  end

  // Sequencer, stack count, error latch and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      // The result state reloads the output register itself.
      if (result_valid && !result_stall && (state != S_RESULT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            sym_q  <= item.symbol;
            last_q <= item.is_last;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (err == ST_OK) begin
            if (is_digit) begin
              if (full) begin
                err <= ST_OVERFLOW;
              end else begin
                count <= count + COUNT_W'(1);
              end
            end else if (is_oper) begin
              if (count < COUNT_W'(2)) begin
                err <= ST_FEW;
              end else if (div_zero) begin
                err <= ST_DIVZERO;
              end
            end else if (!is_blank) begin
              err <= ST_BADCHAR;
            end
          end
          if (alu_req.start) begin
            state <= S_EXEC;
          end else if (last_q) begin
            state <= S_SYNC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EXEC: begin
          if (alu_done) begin
            count <= cnt_m1;
            state <= last_q ? S_SYNC : S_IDLE;
          end
        end
        S_SYNC: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            result       <= result_next;
            count        <= '0;
            err          <= ST_OK;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The stack never holds more than its depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  // The arithmetic unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (state == S_EXEC))
    else $error("arithmetic result outside execute state");

  // Delivering a result starts a fresh expression.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESULT) && !(result_valid && result_stall))
      |=> ((count == '0) && (err == ST_OK) && result_valid))
    else $error("expression state not cleared after result");

  // A failed expression reports a zero value.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_OK)) |-> (result.value == '0))
    else $error("nonzero value with error status");
`endif

endmodule
